// ----- hdl/mersenne_twister_generator_unit_defines.svh -----
// Assertion macros for the generator's RTL.
`ifndef MERSENNE_TWISTER_GENERATOR_UNIT_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MTG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtg: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define MTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtg: next-cycle check failed");

`endif

// ----- hdl/mtg_pkg.sv -----
// Constants and command codes of the MT19937 generator.
package mtg_pkg;

  localparam int WORD_W       = 32;
  localparam int TABLE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int ADDR_W       = $clog2(TABLE_WORDS);
  localparam int POS_W        = $clog2(TABLE_WORDS + 1);

  localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(TABLE_WORDS - 1);
  localparam logic [ADDR_W-1:0] FAR_WRAP  = ADDR_W'(TABLE_WORDS - SHIFT_OFFSET);
  localparam logic [ADDR_W-1:0] FAR_STEP  = ADDR_W'(SHIFT_OFFSET);
  localparam logic [POS_W-1:0]  POS_EMPTY = POS_W'(TABLE_WORDS);

  localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;
  localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;

  typedef enum logic {
    CMD_SEED = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_t;

endpackage

// ----- hdl/mtg_if.sv -----
// Valid/ready channel interfaces for the generator's command and result items.
interface mtg_in_if import mtg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [WORD_W-1:0] seed_value;

  modport source (output valid, output cmd, output seed_value, input ready);
  modport sink (input valid, input cmd, input seed_value, output ready);
endinterface

interface mtg_out_if import mtg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

// ----- hdl/mtg_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic [WIDTH-1:0]         rd_a_data,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_data <= mem_r[rd_a_addr];
    rd_b_data <= mem_r[rd_b_addr];
  end

endmodule

// ----- hdl/mersenne_twister_generator_unit.sv -----
// MT19937 generator: a seed item loads the 624-word state table, a draw item returns
// the next tempered word. The table lives in one RAM with a write port and two
// registered read ports, and a small sequencer walks it one word at a time. A draw
// from a live table reads its word when accepted; ST_DRAW_DONE tempers it into the
// output register. A seed writes word 0 when accepted; each further word waits on
// the single 32x32 multiplier (ST_SEED_MUL), then the add of its index (ST_SEED_ADD).
// The draw that finds the table used up first regenerates it one word at a time, with
// the reads in ST_GEN_LOAD or ST_GEN_READ and the write in ST_GEN_STEP, then reads its
// word. The block takes one item at a time and is not ready while it works; a finished
// result waits in the output register, and a draw cannot finish while the previous
// result is still not taken. Drawing before the first seed returns undefined words.
`include "mersenne_twister_generator_unit_defines.svh"

module mersenne_twister_generator_unit import mtg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  mtg_in_if.sink   in_ch,
  mtg_out_if.source out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_GEN_LOAD,
    ST_GEN_READ,
    ST_GEN_STEP,
    ST_DRAW_READ,
    ST_DRAW_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [WORD_W-1:0] prev_r, prev_nxt;
  logic [WORD_W-1:0] prod_r, prod_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              in_ready;
  logic              in_accept;
  logic              out_load;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_a_addr;
  logic [ADDR_W-1:0] rd_b_addr;
  logic [WORD_W-1:0] rd_a_data;
  logic [WORD_W-1:0] rd_b_data;

  logic [ADDR_W-1:0] idx_inc;
  logic [ADDR_W-1:0] nxt_idx;
  logic [ADDR_W-1:0] far_idx;
  logic [ADDR_W-1:0] pos_addr;
  logic [WORD_W-1:0] seed_mix;
  logic [WORD_W-1:0] seed_word;
  logic [WORD_W-1:0] twist_y;
  logic [WORD_W-1:0] twist_word;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  mtg_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_WORDS)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_a_addr(rd_a_addr),
    .rd_a_data(rd_a_data),
    .rd_b_addr(rd_b_addr),
    .rd_b_data(rd_b_data)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_word = out_word_r;

  assign idx_inc  = idx_r + 1'b1;
  assign nxt_idx  = (idx_r == LAST_IDX) ? '0 : idx_inc;
  assign far_idx  = (idx_r >= FAR_WRAP) ? (idx_r - FAR_WRAP) : (idx_r + FAR_STEP);
  assign pos_addr = (pos_r == POS_EMPTY) ? '0 : pos_r[ADDR_W-1:0];

  assign seed_mix  = prev_r ^ (prev_r >> 30);
  assign seed_word = prod_r + WORD_W'(idx_r);

  assign twist_y    = (cur_r & UPPER_MASK) | (rd_a_data & LOWER_MASK);
  assign twist_word = rd_b_data ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_XOR : '0);

  assign out_load = (state_r == ST_DRAW_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    cur_nxt       = cur_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = seed_word;
    rd_a_addr     = pos_addr;
    rd_b_addr     = far_idx;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_ch.cmd == CMD_SEED) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = in_ch.seed_value;
            prev_nxt  = in_ch.seed_value;
            idx_nxt   = ADDR_W'(1);
            state_nxt = ST_SEED_MUL;
          end else if (pos_r == POS_EMPTY) begin
            idx_nxt   = '0;
            state_nxt = ST_GEN_LOAD;
          end else begin
            state_nxt = ST_DRAW_DONE;
          end
        end
      end
      ST_SEED_MUL: begin
        prod_nxt  = SEED_MULT * seed_mix;
        state_nxt = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        wr_en    = 1'b1;
        prev_nxt = seed_word;
        if (idx_r == LAST_IDX) begin
          pos_nxt   = POS_EMPTY;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_GEN_LOAD: begin
        cur_nxt   = rd_a_data;
        rd_a_addr = nxt_idx;
        state_nxt = ST_GEN_STEP;
      end
      ST_GEN_READ: begin
        rd_a_addr = nxt_idx;
        state_nxt = ST_GEN_STEP;
      end
      ST_GEN_STEP: begin
        wr_en   = 1'b1;
        wr_data = twist_word;
        cur_nxt = rd_a_data;
        if (idx_r == LAST_IDX) begin
          pos_nxt   = '0;
          state_nxt = ST_DRAW_READ;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_GEN_READ;
        end
      end
      ST_DRAW_READ: begin
        state_nxt = ST_DRAW_DONE;
      end
      ST_DRAW_DONE: begin
        if (out_load) begin
          out_word_nxt  = temper(rd_a_data);
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_r + 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= POS_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
  end

  `MTG_ASSERT_NOW(a_draw_pos_live, state_r == ST_DRAW_DONE, pos_r < POS_EMPTY)
  `MTG_ASSERT_NOW(a_write_owner, wr_en,
    state_r == ST_SEED_ADD || state_r == ST_GEN_STEP || (in_accept && in_ch.cmd == CMD_SEED))
  `MTG_ASSERT_NEXT(a_gen_done, state_r == ST_GEN_STEP && idx_r == LAST_IDX,
    pos_r == '0 && state_r == ST_DRAW_READ)
  `MTG_ASSERT_NEXT(a_draw_advance, out_load, out_valid_r && pos_r == $past(pos_r) + 1'b1)

endmodule

// ----- tb/mersenne_twister_generator_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the MT19937 generator: seeds, draws and table twists.
module mersenne_twister_generator_unit_tb;
  import mtg_pkg::*;

  localparam int          CLK_HALF     = 5;
  localparam int          RESET_CYCLES = 9;
  localparam int          MAX_WAIT     = 8;
  localparam int          DRAIN_CYCLES = 1300;
  localparam int unsigned STALL_LIMIT  = 10000;
  localparam int          MIX_ITEMS    = 800;

  logic clk;
  logic rst_n;

  mtg_in_if  in_ch();
  mtg_out_if out_ch();

  mersenne_twister_generator_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [WORD_W-1:0] mt_table [TABLE_WORDS];
  int unsigned       mt_pos;
  logic [WORD_W-1:0] pending_words [$];
  logic [WORD_W-1:0] want_word;

  int unsigned errors        = 0;
  int unsigned seeds_sent    = 0;
  int unsigned draws_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned twists_seen   = 0;
  int unsigned out_wait      = 0;
  int unsigned idle_cycles   = 0;
  bit          no_idle       = 1'b0;

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  function automatic void mt_load_seed(logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] prev;
    mt_table[0] = seed;
    for (int i = 1; i < TABLE_WORDS; i++) begin
      prev = mt_table[i-1];
      mt_table[i] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
    end
    mt_pos = TABLE_WORDS;
  endfunction

  function automatic void mt_twist_table();
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    for (int i = 0; i < TABLE_WORDS; i++) begin
      y = (mt_table[i] & UPPER_MASK) | (mt_table[(i + 1) % TABLE_WORDS] & LOWER_MASK);
      v = mt_table[(i + SHIFT_OFFSET) % TABLE_WORDS] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ TWIST_XOR;
      end
      mt_table[i] = v;
    end
    mt_pos = 0;
    twists_seen++;
  endfunction

  function automatic logic [WORD_W-1:0] mt_temper(logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic void predict_item(cmd_t c, logic [WORD_W-1:0] seed);
    if (c == CMD_SEED) begin
      mt_load_seed(seed);
      seeds_sent++;
    end else begin
      if (mt_pos >= TABLE_WORDS) begin
        mt_twist_table();
      end
      pending_words.push_back(mt_temper(mt_table[mt_pos]));
      mt_pos++;
      draws_sent++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is accepted.
  task automatic send_item(cmd_t c, logic [WORD_W-1:0] seed);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.seed_value <= seed;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    predict_item(c, seed);
    @(negedge clk);
  endtask

  task automatic send_draws(int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      send_item(CMD_DRAW, $urandom);
    end
  endtask

  task automatic test_seed_extremes();
    logic [WORD_W-1:0] seeds [3];
    seeds = '{32'h0000_0000, 32'hffff_ffff, 32'd5489};
    foreach (seeds[k]) begin
      no_idle = (k == 1);
      send_item(CMD_SEED, seeds[k]);
      send_draws(3);
    end
  endtask

  task automatic test_reseed();
    no_idle = 1'b0;
    send_item(CMD_SEED, 32'h5555_5555);
    send_item(CMD_SEED, 32'haaaa_aaaa);
    send_draws(2);
    send_item(CMD_SEED, 32'h0000_0001);
    send_draws(1);
  endtask

  task automatic test_table_regeneration();
    send_item(CMD_SEED, $urandom);
    for (int unsigned k = 0; k < TABLE_WORDS + 76; k++) begin
      if (k % 64 == 0) begin
        no_idle = ($urandom_range(0, 2) == 0);
      end
      send_item(CMD_DRAW, $urandom);
    end
  endtask

  task automatic test_random_mix();
    int unsigned       start_items;
    int unsigned       run_len;
    logic [WORD_W-1:0] seed;
    start_items = seeds_sent + draws_sent;
    while (seeds_sent + draws_sent - start_items < MIX_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0:       seed = 32'h0000_0000;
        1:       seed = 32'hffff_ffff;
        default: seed = $urandom;
      endcase
      send_item(CMD_SEED, seed);
      run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(300, 700)
                                             : $urandom_range(1, 150);
      if (run_len > MIX_ITEMS - (seeds_sent + draws_sent - start_items)) begin
        run_len = MIX_ITEMS - (seeds_sent + draws_sent - start_items);
      end
      for (int unsigned k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 99) == 0) begin
          send_item(CMD_SEED, $urandom);
        end else begin
          send_item(CMD_DRAW, $urandom);
        end
      end
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_wait > 0) begin
        out_ch.ready <= 1'b0;
        out_wait     <= out_wait - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected random_word expected none actual %08h",
                 $time, out_ch.random_word);
      end else begin
        want_word = pending_words.pop_front();
        if (out_ch.random_word !== want_word) begin
          errors++;
          $display("%0t: random_word mismatch expected %08h actual %08h",
                   $time, want_word, out_ch.random_word);
        end
      end
      words_checked++;
      out_wait <= no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_SEED;
    in_ch.seed_value = '0;
    mt_pos           = TABLE_WORDS;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_seed_extremes();
    test_reseed();
    test_table_regeneration();
    test_random_mix();

    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d seed items and %0d draw items; %0d words checked.",
             seeds_sent, draws_sent, words_checked);
    $display("The table was regenerated %0d times; %0d mismatches.", twists_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mtg_pkg.sv
hdl/mtg_if.sv
hdl/mtg_ram.sv
hdl/mersenne_twister_generator_unit.sv
tb/mersenne_twister_generator_unit_tb.sv
